// ===== rtl/phc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID heat/cool controller package
// Shared widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package phc_pkg;

    localparam int TEMP_W   = 16;
    localparam int ERR_W    = TEMP_W + 1;
    localparam int DIFF_W   = TEMP_W + 2;
    localparam int INTEG_W  = 32;
    localparam int GAIN_W   = 16;
    localparam int FRAC_W   = 8;

    localparam int PWM_BITS = 10;
    localparam int DUTY_W   = PWM_BITS + 1;

    // Products use the gain as a signed value with a zero sign bit.
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + INTEG_W;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W    = PROD_I_W + 2;
    localparam int RES_W    = SUM_W - FRAC_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP  = 2'd0,
        REG_GAIN_INTEG = 2'd1,
        REG_GAIN_DERIV = 2'd2
    } cfg_reg_t;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd0;

    localparam logic signed [RES_W-1:0] FULL_SCALE =
        RES_W'(longint'(1) << PWM_BITS);

endpackage

// ===== rtl/phc_sensor_if.sv =====
// ----------------------------------------------------------------------------
// Sensor sample channel
// Valid/ready channel carrying one measured and one target temperature.
// ----------------------------------------------------------------------------
interface phc_sensor_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [phc_pkg::TEMP_W-1:0]     measured_temp;
    logic signed [phc_pkg::TEMP_W-1:0]     target_temp;

    modport source (output valid, output measured_temp, output target_temp, input ready);
    modport sink   (input valid, input measured_temp, input target_temp, output ready);
endinterface

// ===== rtl/phc_drive_if.sv =====
// ----------------------------------------------------------------------------
// Drive command channel
// Valid/ready channel carrying the heat/cool mode, pump and PWM duty.
// ----------------------------------------------------------------------------
interface phc_drive_if;
    logic                          valid;
    logic                          ready;
    logic                          heat_mode;
    logic                          pump_on;
    logic [phc_pkg::DUTY_W-1:0]    duty;

    modport source (output valid, output heat_mode, output pump_on, output duty, input ready);
    modport sink   (input valid, input heat_mode, input pump_on, input duty, output ready);
endinterface

// ===== rtl/phc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface phc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [phc_pkg::CFG_IDX_W-1:0]     index;
    logic [phc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pid_heat_cool_controller_core.sv =====
// ----------------------------------------------------------------------------
// PID heat/cool controller core
// Fixed-point PID loop that turns temperature samples into Peltier drive
// commands (mode, pump, PWM duty).
// ----------------------------------------------------------------------------
//
//   Port     Role      Payload
//   -------  --------  -----------------------------------------
//   sensor   sink      measured_temp, target_temp (signed 16)
//   drive    source    heat_mode, pump_on, duty (PWM_BITS+1)
//   cfg      sink      index (2), data (16); always ready
//
// A sample is captured in the input register, then passes four more stages:
// error and integrator update, the three gain multiplies, the sum and shift,
// then mode and duty into the output register. The result is offered from
// the output register; one sample per cycle while drive is not stalled.
// Reset clears the loop state and loads the default gains. A stalled result
// holds the whole pipeline, so sensor.ready is low only while drive is stalled.
// ----------------------------------------------------------------------------
module pid_heat_cool_controller_core (
    input  logic         clk,
    input  logic         rst_n,
    phc_sensor_if.sink   sensor,
    phc_drive_if.source  drive,
    phc_cfg_if.sink      cfg
);

    // Gains
    logic [phc_pkg::GAIN_W-1:0] gain_prop_reg;
    logic [phc_pkg::GAIN_W-1:0] gain_integ_reg;
    logic [phc_pkg::GAIN_W-1:0] gain_deriv_reg;

    // Loop state
    logic signed [phc_pkg::TEMP_W-1:0]  held_target_reg;
    logic signed [phc_pkg::INTEG_W-1:0] integral_reg;
    logic signed [phc_pkg::ERR_W-1:0]   prev_err_reg;

    // Pipeline valids
    logic a_valid_reg;
    logic b_valid_reg;
    logic c_valid_reg;
    logic d_valid_reg;
    logic out_valid_reg;
    logic advance;

    // Stage A: sample
    logic signed [phc_pkg::TEMP_W-1:0] meas_reg;
    logic signed [phc_pkg::TEMP_W-1:0] targ_reg;

    // Stage A logic
    logic                               targ_change;
    logic signed [phc_pkg::INTEG_W-1:0] integ_base;
    logic signed [phc_pkg::ERR_W-1:0]   err_next;
    logic signed [phc_pkg::INTEG_W:0]   integ_sum;
    logic signed [phc_pkg::INTEG_W-1:0] integral_next;
    logic signed [phc_pkg::DIFF_W-1:0]  diff_next;

    // Stage B: multiply operands
    logic signed [phc_pkg::ERR_W-1:0]   err_reg;
    logic signed [phc_pkg::INTEG_W-1:0] integ_op_reg;
    logic signed [phc_pkg::DIFF_W-1:0]  diff_reg;

    logic signed [phc_pkg::PROD_P_W-1:0] prod_p_next;
    logic signed [phc_pkg::PROD_I_W-1:0] prod_i_next;
    logic signed [phc_pkg::PROD_D_W-1:0] prod_d_next;

    // Stage C: products
    logic signed [phc_pkg::PROD_P_W-1:0] prod_p_reg;
    logic signed [phc_pkg::PROD_I_W-1:0] prod_i_reg;
    logic signed [phc_pkg::PROD_D_W-1:0] prod_d_reg;

    logic signed [phc_pkg::SUM_W-1:0] sum_full;
    logic signed [phc_pkg::RES_W-1:0] res_next;
    logic signed [phc_pkg::RES_W-1:0] res_reg;

    // Output stage
    logic                             heat_next;
    logic signed [phc_pkg::RES_W-1:0] mag;
    logic [phc_pkg::DUTY_W-1:0]       duty_next;
    logic                             heat_reg;
    logic [phc_pkg::DUTY_W-1:0]       duty_reg;

    assign advance      = !out_valid_reg || drive.ready;
    assign sensor.ready = advance;
    assign cfg.ready    = 1'b1;

    assign drive.valid     = out_valid_reg;
    assign drive.heat_mode = heat_reg;
    assign drive.pump_on   = !heat_reg;
    assign drive.duty      = duty_reg;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= phc_pkg::GAIN_PROP_RST;
            gain_integ_reg <= phc_pkg::GAIN_INTEG_RST;
            gain_deriv_reg <= phc_pkg::GAIN_DERIV_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                phc_pkg::REG_GAIN_PROP:  gain_prop_reg  <= cfg.data;
                phc_pkg::REG_GAIN_INTEG: gain_integ_reg <= cfg.data;
                phc_pkg::REG_GAIN_DERIV: gain_deriv_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Stage A: a new target clears the integrator before this error is added.
    always_comb
    begin
        targ_change = (targ_reg != held_target_reg);
        integ_base  = targ_change ? '0 : integral_reg;
        err_next    = phc_pkg::ERR_W'(targ_reg) - phc_pkg::ERR_W'(meas_reg);
        integ_sum   = (phc_pkg::INTEG_W+1)'(integ_base) + (phc_pkg::INTEG_W+1)'(err_next);
        if (integ_sum[phc_pkg::INTEG_W] != integ_sum[phc_pkg::INTEG_W-1])
        begin
            // Overflow: saturate toward the sign of the true sum.
            integral_next = integ_sum[phc_pkg::INTEG_W]
                ? {1'b1, {(phc_pkg::INTEG_W-1){1'b0}}}
                : {1'b0, {(phc_pkg::INTEG_W-1){1'b1}}};
        end
        else
        begin
            integral_next = integ_sum[phc_pkg::INTEG_W-1:0];
        end
        diff_next = phc_pkg::DIFF_W'(err_next) - phc_pkg::DIFF_W'(prev_err_reg);
    end

    // Stage B: three multiplies, gains as non-negative signed values.
    always_comb
    begin
        prod_p_next = phc_pkg::PROD_P_W'($signed({1'b0, gain_prop_reg}))
                    * phc_pkg::PROD_P_W'(err_reg);
        prod_i_next = phc_pkg::PROD_I_W'($signed({1'b0, gain_integ_reg}))
                    * phc_pkg::PROD_I_W'(integ_op_reg);
        prod_d_next = phc_pkg::PROD_D_W'($signed({1'b0, gain_deriv_reg}))
                    * phc_pkg::PROD_D_W'(diff_reg);
    end

    // Stage C: sum, then an arithmetic shift gives the floor of the divide.
    always_comb
    begin
        sum_full = phc_pkg::SUM_W'(prod_p_reg) + phc_pkg::SUM_W'(prod_i_reg)
                 + phc_pkg::SUM_W'(prod_d_reg);
        res_next = sum_full[phc_pkg::SUM_W-1:phc_pkg::FRAC_W];
    end

    // Output stage: zero counts as cool mode.
    always_comb
    begin
        heat_next = !res_reg[phc_pkg::RES_W-1] && (res_reg != '0);
        mag       = heat_next ? res_reg : -res_reg;
        if (mag > phc_pkg::FULL_SCALE)
        begin
            duty_next = phc_pkg::FULL_SCALE[phc_pkg::DUTY_W-1:0];
        end
        else
        begin
            duty_next = mag[phc_pkg::DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            d_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            held_target_reg <= '0;
            integral_reg    <= '0;
            prev_err_reg    <= '0;
        end
        else if (advance)
        begin
            a_valid_reg   <= sensor.valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
            if (a_valid_reg)
            begin
                held_target_reg <= targ_reg;
                integral_reg    <= integral_next;
                prev_err_reg    <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            meas_reg     <= sensor.measured_temp;
            targ_reg     <= sensor.target_temp;
            err_reg      <= err_next;
            integ_op_reg <= integral_next;
            diff_reg     <= diff_next;
            prod_p_reg   <= prod_p_next;
            prod_i_reg   <= prod_i_next;
            prod_d_reg   <= prod_d_next;
            res_reg      <= res_next;
            heat_reg     <= heat_next;
            duty_reg     <= duty_next;
        end
    end

endmodule

// ===== tb/phc_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID heat/cool drive checker
// Watches the sensor, drive and configuration channels of the controller core.
// It keeps its own copy of the gains and loop state and predicts the drive
// command of every accepted sample. Each drive transfer is compared field by
// field with the oldest prediction. Failures and the number of outstanding
// predictions are handed to the testbench top.
// ----------------------------------------------------------------------------
module phc_drive_checker
    import phc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sensor_valid,
    input  logic                        sensor_ready,
    input  logic signed [TEMP_W-1:0]    measured_temp,
    input  logic signed [TEMP_W-1:0]    target_temp,
    input  logic                        drive_valid,
    input  logic                        drive_ready,
    input  logic                        heat_mode,
    input  logic                        pump_on,
    input  logic [DUTY_W-1:0]           duty,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          fail_count,
    output int                          outstanding
);

    typedef struct packed {
        logic               heat_mode;
        logic               pump_on;
        logic [DUTY_W-1:0]  duty;
    } drive_cmd_t;

    localparam longint INTEG_HI  = (longint'(1) << (INTEG_W - 1)) - 1;
    localparam longint INTEG_LO  = -(longint'(1) << (INTEG_W - 1));
    localparam longint FULL_DUTY = longint'(1) << PWM_BITS;

    logic [GAIN_W-1:0]          kp;
    logic [GAIN_W-1:0]          ki;
    logic [GAIN_W-1:0]          kd;
    logic signed [TEMP_W-1:0]   setpoint;
    logic signed [INTEG_W-1:0]  integ_acc;
    logic signed [ERR_W-1:0]    last_err;

    drive_cmd_t drive_expected[$];
    int         results_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] drive result %0d: %s", $time, results_seen, msg);
        fail_count++;
    endtask

    // Advances the loop state by one sample and returns the drive command.
    function automatic drive_cmd_t predict_drive(input logic signed [TEMP_W-1:0] meas,
                                                 input logic signed [TEMP_W-1:0] targ);
        longint     err;
        longint     diff;
        longint     acc;
        longint     res;
        longint     mag;
        drive_cmd_t cmd;

        // A new target restarts the integrator before this sample is added.
        if (targ != setpoint)
        begin
            setpoint  = targ;
            integ_acc = '0;
        end

        err = longint'(setpoint) - longint'(meas);
        acc = longint'(integ_acc) + err;
        if (acc > INTEG_HI)
            acc = INTEG_HI;
        else if (acc < INTEG_LO)
            acc = INTEG_LO;
        integ_acc = INTEG_W'(acc);

        diff     = err - longint'(last_err);
        last_err = ERR_W'(err);

        res = longint'(kp) * err + longint'(ki) * longint'(integ_acc)
            + longint'(kd) * diff;
        res = res >>> FRAC_W;

        cmd.heat_mode = (res > 0);
        cmd.pump_on   = !cmd.heat_mode;
        mag = (res > 0) ? res : -res;
        if (mag > FULL_DUTY)
            mag = FULL_DUTY;
        cmd.duty = DUTY_W'(mag);
        return cmd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_cmd_t got;
        drive_cmd_t want;

        if (!rst_n)
        begin
            drive_expected.delete();
            kp           = GAIN_PROP_RST;
            ki           = GAIN_INTEG_RST;
            kd           = GAIN_DERIV_RST;
            setpoint     = '0;
            integ_acc    = '0;
            last_err     = '0;
            results_seen = 0;
            fail_count   = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_PROP:  kp = cfg_data;
                    REG_GAIN_INTEG: ki = cfg_data;
                    REG_GAIN_DERIV: kd = cfg_data;
                    default: ;
                endcase
            end

            // Results are retired before the new sample is queued.
            if (drive_valid && drive_ready)
            begin
                got.heat_mode = heat_mode;
                got.pump_on   = pump_on;
                got.duty      = duty;
                results_seen++;
                if (drive_expected.size() == 0)
                begin
                    report_mismatch("transfer with no sample waiting");
                end
                else
                begin
                    want = drive_expected.pop_front();
                    if (got.heat_mode !== want.heat_mode)
                        report_mismatch($sformatf("heat_mode expected %0b, got %0b",
                                                  want.heat_mode, got.heat_mode));
                    if (got.pump_on !== want.pump_on)
                        report_mismatch($sformatf("pump_on expected %0b, got %0b",
                                                  want.pump_on, got.pump_on));
                    if (got.duty !== want.duty)
                        report_mismatch($sformatf("duty expected %0d, got %0d",
                                                  want.duty, got.duty));
                end
            end

            if (sensor_valid && sensor_ready)
                drive_expected.push_back(predict_drive(measured_temp, target_temp));

            outstanding = drive_expected.size();
        end
    end

endmodule

// ===== tb/pid_heat_cool_controller_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID heat/cool controller core testbench
// Drives temperature samples and gain writes into the core and lets the drive
// checker predict and compare every drive command. A directed part covers the
// field extremes, rounding and clamping corners, then random sample sequences
// run under several gain settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module pid_heat_cool_controller_core_tb;
    import phc_pkg::*;

    localparam int CLK_PERIOD       = 4;
    localparam int RESET_CYCLES     = 11;
    localparam int PIPE_LATENCY     = 4;
    localparam int STALL_LIMIT      = 4000;
    localparam int RANDOM_PER_PHASE = 182;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX  = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN  = 16'sh8000;
    localparam logic [GAIN_W-1:0]        GAIN_MAX  = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0]     REG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int fail_count;
    int outstanding;
    int idle_cycles    = 0;

    phc_sensor_if sensor_ch();
    phc_drive_if  drive_ch();
    phc_cfg_if    cfg_ch();

    always #(CLK_PERIOD / 2) clk = ~clk;

    pid_heat_cool_controller_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor_ch),
        .drive  (drive_ch),
        .cfg    (cfg_ch)
    );

    phc_drive_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sensor_valid  (sensor_ch.valid),
        .sensor_ready  (sensor_ch.ready),
        .measured_temp (sensor_ch.measured_temp),
        .target_temp   (sensor_ch.target_temp),
        .drive_valid   (drive_ch.valid),
        .drive_ready   (drive_ch.ready),
        .heat_mode     (drive_ch.heat_mode),
        .pump_on       (drive_ch.pump_on),
        .duty          (drive_ch.duty),
        .cfg_valid     (cfg_ch.valid),
        .cfg_ready     (cfg_ch.ready),
        .cfg_index     (cfg_ch.index),
        .cfg_data      (cfg_ch.data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // The drive side stalls at random according to the current phase.
    initial
    begin
        drive_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            drive_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sensor_ch.valid && sensor_ch.ready) || (drive_ch.valid && drive_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL pid_heat_cool_controller_core");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic signed [TEMP_W-1:0] meas,
                               input logic signed [TEMP_W-1:0] targ);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sensor_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sensor_ch.valid         <= 1'b1;
        sensor_ch.measured_temp <= meas;
        sensor_ch.target_temp   <= targ;
        @(posedge clk);
        while (!sensor_ch.ready)
            @(posedge clk);
    endtask

    // Holds the sensor side off until every predicted command has come out.
    task automatic wait_results_drained();
        @(negedge clk);
        sensor_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                              input logic [GAIN_W-1:0] d);
        wait_results_drained();
        write_gain(REG_GAIN_PROP, p);
        write_gain(REG_GAIN_INTEG, i);
        write_gain(REG_GAIN_DERIV, d);
        // The unused index must leave all three gains alone.
        write_gain(REG_SPARE, CFG_DATA_W'($urandom));
    endtask

    // Runs of samples against a held target, mostly close to it so that the
    // integrator and derivative terms build up, with some wild readings.
    task automatic run_random(input int count);
        int                         left;
        int                         pick;
        int                         m;
        logic signed [TEMP_W-1:0]   tgt;
        logic signed [TEMP_W-1:0]   meas;

        left = 0;
        tgt  = '0;
        for (int n = 0; n < count; n++)
        begin
            if (left == 0)
            begin
                left = $urandom_range(40, 1);
                if ($urandom_range(3) == 0)
                    tgt = $urandom_range(1) ? TEMP_MAX : TEMP_MIN;
                else
                    tgt = TEMP_W'($urandom);
            end
            left--;

            pick = $urandom_range(99);
            if (pick < 60)
            begin
                m = int'(tgt) + int'($urandom_range(600)) - 300;
                if (m > int'(TEMP_MAX))
                    m = int'(TEMP_MAX);
                if (m < int'(TEMP_MIN))
                    m = int'(TEMP_MIN);
                meas = TEMP_W'(m);
            end
            else if (pick < 85)
                meas = TEMP_W'($urandom);
            else
                meas = pick[0] ? TEMP_MAX : TEMP_MIN;

            if ($urandom_range(149) == 0)
                wait_results_drained();
            send_sample(meas, tgt);
        end
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        sensor_ch.valid         = 1'b0;
        sensor_ch.measured_temp = '0;
        sensor_ch.target_temp   = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_GAIN_PROP;
        cfg_ch.data             = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset gains: the output equals the error, so duty shows it directly.
        send_sample(16'sd0, 16'sd0);
        send_sample(TEMP_MIN, TEMP_MAX);
        send_sample(TEMP_MAX, TEMP_MAX);
        send_sample(TEMP_MAX, TEMP_MIN);
        send_sample(TEMP_MIN, TEMP_MIN);
        send_sample(16'sd100, 16'sd101);
        send_sample(16'sd101, 16'sd100);
        send_sample(16'sd0, 16'sd1024);
        send_sample(16'sd0, 16'sd1025);
        send_sample(16'sd0, -16'sd1024);
        send_sample(16'sd0, -16'sd1025);

        // Tiny gain: the shift rounds toward minus infinity.
        load_gains(16'd1, 16'd0, 16'd0);
        send_sample(16'sd9, 16'sd10);
        send_sample(16'sd11, 16'sd10);
        send_sample(-16'sd245, 16'sd10);
        send_sample(-16'sd246, 16'sd10);

        load_gains(16'd256, 16'd256, 16'd256);
        send_sample(16'sd0, 16'sd10);
        send_sample(16'sd5, 16'sd10);
        send_sample(16'sd20, 16'sd10);
        send_sample(16'sd10, 16'sd10);
        send_sample(16'sd10, 16'sd40);

        for (int k = 0; k < 8; k++)
        begin
            case (k)
                0: load_gains(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST);
                1: load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
                2: load_gains(16'd0, 16'd0, 16'd0);
                3: load_gains(GAIN_W'($urandom_range(1023)), GAIN_W'($urandom_range(3)),
                              GAIN_W'($urandom_range(1023)));
                4: load_gains(16'd1, 16'd1, 16'd1);
                5: load_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
                6: load_gains(16'd0, GAIN_MAX, 16'd0);
                default: load_gains(GAIN_W'($urandom_range(511)), GAIN_W'($urandom_range(7)),
                                    GAIN_MAX);
            endcase
            case (k / 2)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 81;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 81;
                end
                default:
                begin
                    src_idle_pct   = 37;
                    sink_stall_pct = 37;
                end
            endcase
            run_random(RANDOM_PER_PHASE);
        end

        wait_results_drained();
        repeat (2 * PIPE_LATENCY) @(negedge clk);
        if (fail_count == 0)
            $display("PASS pid_heat_cool_controller_core");
        else
            $display("FAIL pid_heat_cool_controller_core");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/phc_pkg.sv
rtl/phc_sensor_if.sv
rtl/phc_drive_if.sv
rtl/phc_cfg_if.sv
rtl/pid_heat_cool_controller_core.sv
tb/phc_drive_checker.sv
tb/pid_heat_cool_controller_core_tb.sv
